FILE: rtl/core/cpd_pkg.sv
// Package for the card pool draw and remove block: shared widths, command
// and status codes, request and result structs, and parameter defaults.
// Depends on nothing.
package cpd_pkg;

	// field widths
	localparam int CMD_W  = 2;
	localparam int RND_W  = 31;
	localparam int VAL_W  = 4;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 10;
	localparam int GRP_W  = 8;

	// parameter defaults
	localparam int MAX_DECKS_DEF  = 8;
	localparam int POOL_DEPTH_DEF = 512;

	// deck count after reset
	localparam logic [VAL_W-1:0] DECKS_RESET = 4'd8;

	// deck layout: values two to nine and eleven come four per deck, ten sixteen
	localparam logic [VAL_W-1:0] VAL_FIRST      = 4'd2;
	localparam logic [VAL_W-1:0] VAL_TEN        = 4'd10;
	localparam logic [VAL_W-1:0] VAL_LAST       = 4'd11;
	localparam int               TEN_PER_DECK   = 16;
	localparam int               OTHER_PER_DECK = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_DEAL   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [RND_W-1:0] random_value;
		logic [VAL_W-1:0] card_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  dealt_value;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  remaining;
	} rsp_t;

endpackage

FILE: rtl/core/cpd_ram.sv
// Pool storage: single-port synchronous RAM of card values, registered read.
// Depends on cpd_pkg for the value width.
module cpd_ram #(
	parameter int DEPTH = cpd_pkg::POOL_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [AW-1:0]            addr,
	input  logic [cpd_pkg::VAL_W-1:0] wdata,
	output logic [cpd_pkg::VAL_W-1:0] rdata
);
	import cpd_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];

	// write or read one entry per cycle, read data registered
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: rtl/core/cpd_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on cpd_pkg for the dividend and count widths.
module cpd_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cpd_pkg::RND_W-1:0] dividend,
	input  logic [cpd_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [cpd_pkg::CNT_W-1:0] rem
);
	import cpd_pkg::*;

	localparam int SW = $clog2(RND_W);
	localparam logic [SW-1:0] LAST_STEP = SW'(RND_W - 1);

	logic             run_q;
	logic             done_q;
	logic [SW-1:0]    step_q;
	logic [RND_W-1:0] dvd_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W-1:0] rem_q;

	logic [CNT_W:0] shifted;
	logic [CNT_W:0] reduced;

	// shift in the next dividend bit, subtract the divisor if it fits
	always_comb begin
		shifted = {rem_q, dvd_q[RND_W-1]};
		if (shifted >= {1'b0, div_q}) begin
			reduced = shifted - {1'b0, div_q};
		end else begin
			reduced = shifted;
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				dvd_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
			end else if (run_q) begin
				rem_q  <= reduced[CNT_W-1:0];
				dvd_q  <= {dvd_q[RND_W-2:0], 1'b0};
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (divisor != '0))
		else $error("remainder started with zero divisor");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("remainder restarted while running");

endmodule

FILE: rtl/core/card_pool_draw_and_remove_top.sv
// Card pool that deals random cards and removes given values without
// replacement. A request is taken when start is high and busy is low; its one
// result appears on rsp for exactly one cycle with done high and cannot be
// stalled, so the receiver must take it then. One request is worked at a time.
// A deal runs the bit-serial remainder over the 31-bit random value, then the
// pool reads and the swap write. A remove scans the pool one entry per cycle
// through the single RAM port. A refill writes one entry per cycle, 52 per
// deck unless the pool fills first. An unused command and a deal on an empty
// pool go straight to the response. No clearing pass runs after reset; the
// deck count is to be written by the user through cfg_we and cfg_data while
// idle, and the block itself does not enforce it.
module card_pool_draw_and_remove_top #(
	parameter int MAX_DECKS  = cpd_pkg::MAX_DECKS_DEF,
	parameter int POOL_DEPTH = cpd_pkg::POOL_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  cpd_pkg::req_t             req,
	output logic                      done,
	output cpd_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [cpd_pkg::VAL_W-1:0] cfg_data
);
	import cpd_pkg::*;

	localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);
	localparam logic [VAL_W-1:0] DECKS_MAX = VAL_W'(MAX_DECKS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_DCAP = 3'd2;
	localparam logic [2:0] S_TAKE = 3'd3;
	localparam logic [2:0] S_MOVE = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_FILL = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [VAL_W-1:0]  decks_q;
	logic [VAL_W-1:0]  card_q;
	logic [AW-1:0]     pos_q;
	logic [VAL_W-1:0]  dealt_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  scan_idx_q;
	logic [AW-1:0]     chk_idx_q;
	logic              rv_q;
	logic [VAL_W-1:0]  fill_val_q;
	logic [GRP_W-1:0]  fill_k_q;
	logic [VAL_W-1:0]  fill_d_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [CNT_W-1:0]  div_rem;
	logic [CNT_W-1:0]  last;
	logic              move_needed;
	logic              scan_more;
	logic              hit;
	logic              issue;
	logic              fill_end;
	logic [GRP_W-1:0]  grp_size;
	logic [VAL_W-1:0]  decks_clamped;

	logic              ram_en;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [VAL_W-1:0]  ram_rdata;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// start the remainder for a deal on a non-empty pool
	assign div_start = accept && (req.cmd == CMD_DEAL) && (count_q != '0);

	// swap-remove bookkeeping
	assign last        = count_q - 1'b1;
	assign move_needed = CNT_W'(pos_q) < last;

	// scan pipeline: compare the entry read last cycle, issue the next
	assign scan_more = scan_idx_q < count_q;
	assign hit       = rv_q && (ram_rdata == card_q);
	assign issue     = scan_more && !hit;

	// refill walk: group size follows the current value
	assign fill_end = (count_q == DEPTH_CNT) || (fill_val_q > VAL_LAST);
	assign grp_size = (fill_val_q == VAL_TEN)
		? GRP_W'(fill_d_q) * GRP_W'(TEN_PER_DECK)
		: GRP_W'(fill_d_q) * GRP_W'(OTHER_PER_DECK);

	// clamp deck count into one to the maximum
	always_comb begin
		if (decks_q == '0) begin
			decks_clamped = VAL_W'(1);
		end else if (decks_q > DECKS_MAX) begin
			decks_clamped = DECKS_MAX;
		end else begin
			decks_clamped = decks_q;
		end
	end

	// drive the pool port from the current state
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = fill_val_q;
		unique case (state_q)
			S_DIV: begin
				if (div_done) begin
					ram_en   = 1'b1;
					ram_addr = div_rem[AW-1:0];
				end
			end
			S_TAKE: begin
				if (move_needed) begin
					ram_en   = 1'b1;
					ram_addr = last[AW-1:0];
				end
			end
			S_MOVE: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = pos_q;
				ram_wdata = ram_rdata;
			end
			S_SCAN: begin
				if (issue) begin
					ram_en   = 1'b1;
					ram_addr = scan_idx_q[AW-1:0];
				end
			end
			S_FILL: begin
				if (!fill_end) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = count_q[AW-1:0];
					ram_wdata = fill_val_q;
				end
			end
			default: begin
			end
		endcase
	end

	// hold the deck count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decks_q <= DECKS_RESET;
		end else if (cfg_we) begin
			decks_q <= cfg_data;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			card_q     <= '0;
			pos_q      <= '0;
			dealt_q    <= '0;
			status_q   <= STAT_OK;
			scan_idx_q <= '0;
			chk_idx_q  <= '0;
			rv_q       <= 1'b0;
			fill_val_q <= '0;
			fill_k_q   <= '0;
			fill_d_q   <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						dealt_q  <= '0;
						status_q <= STAT_OK;
						card_q   <= req.card_value;
						unique case (req.cmd)
							CMD_DEAL: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_DIV;
								end
							end
							CMD_REMOVE: begin
								scan_idx_q <= '0;
								rv_q       <= 1'b0;
								state_q    <= S_SCAN;
							end
							CMD_REFILL: begin
								count_q    <= '0;
								fill_val_q <= VAL_FIRST;
								fill_k_q   <= '0;
								fill_d_q   <= decks_clamped;
								state_q    <= S_FILL;
							end
							CMD_NOP: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						pos_q   <= div_rem[AW-1:0];
						state_q <= S_DCAP;
					end
				end
				S_DCAP: begin
					dealt_q <= ram_rdata;
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					count_q <= last;
					state_q <= move_needed ? S_MOVE : S_RESP;
				end
				S_MOVE: begin
					state_q <= S_RESP;
				end
				S_SCAN: begin
					rv_q      <= issue;
					chk_idx_q <= scan_idx_q[AW-1:0];
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (hit) begin
						pos_q   <= chk_idx_q;
						state_q <= S_TAKE;
					end else if (!rv_q && !scan_more) begin
						status_q <= STAT_NOT_FOUND;
						state_q  <= S_RESP;
					end
				end
				S_FILL: begin
					if (fill_end) begin
						state_q <= S_RESP;
					end else begin
						count_q <= count_q + 1'b1;
						if (fill_k_q == grp_size - 1'b1) begin
							fill_val_q <= fill_val_q + 1'b1;
							fill_k_q   <= '0;
						end else begin
							fill_k_q <= fill_k_q + 1'b1;
						end
					end
				end
				S_RESP: begin
					done_q            <= 1'b1;
					rsp_q.dealt_value <= dealt_q;
					rsp_q.status      <= status_q;
					rsp_q.remaining   <= count_q;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	cpd_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.random_value),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	cpd_ram #(
		.DEPTH (POOL_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("live count above pool depth");

	a_move_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> (CNT_W'(pos_q) < count_q))
		else $error("swap write outside live entries");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && rv_q) |-> (CNT_W'(chk_idx_q) < count_q))
		else $error("scan compared an entry beyond the live count");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

endmodule
